/* src/cfa_pkg.sv */
// ----------------------------------------------------------------------------
// cfa_pkg
// Shared types and constants of the contiguous frame allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package cfa_pkg;

    localparam int MAX_FRAMES = 8192;
    localparam int IDX_W      = $clog2(MAX_FRAMES);
    localparam int POS_W      = IDX_W + 1;

    localparam int FRAME_W    = 20;
    localparam int LEN_W      = 14;
    localparam int FREE_W     = 14;
    localparam int KIND_W     = 2;
    localparam int STAT_W     = 2;
    localparam int FST_W      = 2;
    localparam int CFG_W      = 20;
    localparam int CFG_IDX_W  = 1;

    // effective pool size after reset: min(8192, MAX_FRAMES)
    localparam logic [LEN_W-1:0] SIZE_RST = LEN_W'((8192 < MAX_FRAMES) ? 8192 : MAX_FRAMES);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_SIZE = 1'b1;

    // per-frame state codes
    localparam logic [FST_W-1:0] FS_HEAD  = 2'd1;
    localparam logic [FST_W-1:0] FS_ALLOC = 2'd2;
    localparam logic [FST_W-1:0] FS_FREE  = 2'd3;

    typedef enum logic [KIND_W-1:0] {
        K_ALLOC   = 2'd0,
        K_RELEASE = 2'd1,
        K_MARK    = 2'd2,
        K_NONE    = 2'd3
    } t_kind;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_NO_SPACE = 2'd1,
        ST_NOT_HEAD = 2'd2,
        ST_RANGE    = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_MARK,
        S_REL,
        S_DONE
    } t_state;

    typedef struct packed {
        logic               reinit;
        logic [FRAME_W-1:0] base;
        logic [LEN_W-1:0]   size;
    } t_cfg;

    typedef struct packed {
        logic [FRAME_W-1:0] head;
        t_status            status;
        logic [FREE_W-1:0]  free_frames;
    } t_result;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [FST_W-1:0] wdata;
        logic             re;
        logic [IDX_W-1:0] raddr;
    } t_ram_req;

endpackage

`default_nettype wire

/* src/cfa_req_if.sv */
// ----------------------------------------------------------------------------
// cfa_req_if
// Request channel: valid/ready handshake carrying one request word.
// ----------------------------------------------------------------------------
`default_nettype none

interface cfa_req_if import cfa_pkg::*; ();

    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic [FRAME_W-1:0] frame_num;
    logic [LEN_W-1:0]   run_length;

    modport source (output valid, output kind, output frame_num, output run_length,
                    input ready);
    modport sink   (input valid, input kind, input frame_num, input run_length,
                    output ready);

endinterface

`default_nettype wire

/* src/cfa_rsp_if.sv */
// ----------------------------------------------------------------------------
// cfa_rsp_if
// Response channel: valid/ready handshake carrying one result word.
// ----------------------------------------------------------------------------
`default_nettype none

interface cfa_rsp_if import cfa_pkg::*; ();

    logic               valid;
    logic               ready;
    logic [FRAME_W-1:0] head_frame;
    logic [STAT_W-1:0]  status;
    logic [FREE_W-1:0]  free_frames;

    modport source (output valid, output head_frame, output status, output free_frames,
                    input ready);
    modport sink   (input valid, input head_frame, input status, input free_frames,
                    output ready);

endinterface

`default_nettype wire

/* src/contiguous_frame_allocator.sv */
// ----------------------------------------------------------------------------
// contiguous_frame_allocator
// First-fit allocator of contiguous frame runs over a 2-bit-per-frame RAM.
//
//   port            dir   handshake      word
//   i_req           in    valid/ready    kind, frame_num, run_length
//   o_rsp           out   valid/ready    head_frame, status, free_frames
//   i_cfg_*         in    write enable   register index, write data
//
// One frame per cycle through the state RAM read port, which has a registered
// read. Allocate: decode, first-fit scan, mark the run found, done.
// Release: decode, release walk, done; mark: decode, mark walk, done.
// After reset and after every register write a clearing pass writes all
// MAX_FRAMES entries free; no request is accepted meanwhile.
// A finished result sits in the output register while the next request runs.
// ----------------------------------------------------------------------------
`default_nettype none

module contiguous_frame_allocator import cfa_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    cfa_req_if.sink                   i_req,
    cfa_rsp_if.source                 o_rsp
);

    logic [FRAME_W-1:0] r_base, n_base;
    logic [LEN_W-1:0]   r_size, n_size;
    logic               r_rsp_vld, n_rsp_vld;
    t_result            r_rsp, n_rsp;

    t_cfg               cfg;
    t_ram_req           ram_req;
    logic [FST_W-1:0]   ram_rdata;
    logic               res_valid;
    t_result            res;
    logic               res_ack;

    // register writes; pool size is clamped to the RAM depth
    always_comb begin
        n_base = r_base;
        n_size = r_size;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_POOL_BASE: n_base = i_cfg_data[FRAME_W-1:0];
                CFG_POOL_SIZE: begin
                    if (int'(i_cfg_data[LEN_W-1:0]) > MAX_FRAMES) n_size = LEN_W'(MAX_FRAMES);
                    else n_size = i_cfg_data[LEN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign cfg.reinit = i_cfg_we;
    assign cfg.base   = r_base;
    assign cfg.size   = r_size;

    // output register
    assign res_ack = res_valid && (!r_rsp_vld || o_rsp.ready);

    always_comb begin
        n_rsp_vld = r_rsp_vld;
        n_rsp     = r_rsp;
        if (res_ack) begin
            n_rsp_vld = 1'b1;
            n_rsp     = res;
        end else if (o_rsp.ready) begin
            n_rsp_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base    <= '0;
            r_size    <= SIZE_RST;
            r_rsp_vld <= 1'b0;
        end else begin
            r_base    <= n_base;
            r_size    <= n_size;
            r_rsp_vld <= n_rsp_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rsp <= n_rsp;
    end

    assign o_rsp.valid       = r_rsp_vld;
    assign o_rsp.head_frame  = r_rsp.head;
    assign o_rsp.status      = r_rsp.status;
    assign o_rsp.free_frames = r_rsp.free_frames;

    cfa_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_req       (i_req),
        .o_ram       (ram_req),
        .i_ram_rdata (ram_rdata),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ack   (res_ack)
    );

    cfa_frame_ram #(
        .DEPTH (MAX_FRAMES),
        .WIDTH (FST_W)
    ) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_re    (ram_req.re),
        .i_raddr (ram_req.raddr),
        .o_rdata (ram_rdata)
    );

endmodule

`default_nettype wire

/* src/cfa_frame_ram.sv */
// ----------------------------------------------------------------------------
// cfa_frame_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module cfa_frame_ram #(
    parameter int DEPTH = 8192,
    parameter int WIDTH = 2
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

/* src/cfa_engine.sv */
// ----------------------------------------------------------------------------
// cfa_engine
// Request sequencer: clearing pass, first-fit scan, run marking and release
// walk over the frame-state RAM, plus the free-frame counter.
// ----------------------------------------------------------------------------
`default_nettype none

module cfa_engine import cfa_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_cfg             i_cfg,
    cfa_req_if.sink               i_req,
    output t_ram_req              o_ram,
    input  wire logic [FST_W-1:0] i_ram_rdata,
    output logic                  o_res_valid,
    output t_result               o_res,
    input  wire logic             i_res_ack
);

    t_state             r_state, n_state;
    t_kind              r_kind, n_kind;
    logic [FRAME_W-1:0] r_fno, n_fno;
    logic [LEN_W-1:0]   r_len, n_len;
    logic [POS_W-1:0]   r_rd_pos, n_rd_pos;
    logic [POS_W-1:0]   r_lim, n_lim;
    logic               r_dv, n_dv;
    logic [IDX_W-1:0]   r_dpos, n_dpos;
    logic [LEN_W-1:0]   r_run, n_run;
    logic               r_first, n_first;
    logic [FREE_W-1:0]  r_free, n_free;
    logic [FRAME_W-1:0] r_head, n_head;
    t_status            r_status, n_status;
    logic [POS_W-1:0]   r_clr, n_clr;

    logic [FRAME_W-1:0] off;
    logic               in_pool;
    logic               mark_fits;
    logic               alloc_bad;
    logic               streaming;
    logic               issue;
    logic               stream_end;
    logic               rd_free;
    logic               rd_head;
    logic               found;
    logic               rel_stop;
    logic               clr_last;
    logic [IDX_W-1:0]   fit_start;

    assign off       = r_fno - i_cfg.base;
    assign in_pool   = (r_fno >= i_cfg.base) && (off < FRAME_W'(i_cfg.size));
    assign mark_fits = FRAME_W'(r_len) <= (FRAME_W'(i_cfg.size) - off);
    assign alloc_bad = (r_len > r_free) || (r_len > i_cfg.size);

    assign streaming  = (r_state == S_SCAN) || (r_state == S_MARK) || (r_state == S_REL);
    assign issue      = streaming && (r_rd_pos < r_lim);
    assign stream_end = !r_dv && !(r_rd_pos < r_lim);

    assign rd_free = (i_ram_rdata == FS_FREE);
    assign rd_head = (i_ram_rdata == FS_HEAD);

    // run completes at the frame now on the read port
    assign found     = r_dv && rd_free && ((r_run + LEN_W'(1)) == r_len);
    assign fit_start = r_dpos + IDX_W'(1) - IDX_W'(r_len);

    // first frame must be a head; later frames end the walk at head or free
    assign rel_stop = r_dv && (r_first ? !rd_head : (rd_head || rd_free));

    assign clr_last = (r_clr == POS_W'(MAX_FRAMES - 1));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_req.valid) n_state = S_DECODE;
            end
            S_DECODE: begin
                unique case (r_kind)
                    K_ALLOC: begin
                        n_state = ((r_len == '0) || alloc_bad) ? S_DONE : S_SCAN;
                    end
                    K_RELEASE: begin
                        n_state = in_pool ? S_REL : S_DONE;
                    end
                    K_MARK: begin
                        n_state = ((r_len != '0) && in_pool && mark_fits) ? S_MARK : S_DONE;
                    end
                    K_NONE: begin
                        n_state = S_DONE;
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_SCAN: begin
                if (found)           n_state = S_MARK;
                else if (stream_end) n_state = S_DONE;
            end
            S_MARK: begin
                if (stream_end) n_state = S_DONE;
            end
            S_REL: begin
                if (rel_stop || stream_end) n_state = S_DONE;
            end
            S_DONE: begin
                if (i_res_ack) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
        if (i_cfg.reinit) n_state = S_CLEAR;
    end

    // datapath and RAM controls
    always_comb begin
        n_kind   = r_kind;
        n_fno    = r_fno;
        n_len    = r_len;
        n_rd_pos = r_rd_pos;
        n_lim    = r_lim;
        n_dv     = 1'b0;
        n_dpos   = r_rd_pos[IDX_W-1:0];
        n_run    = r_run;
        n_first  = r_first;
        n_free   = r_free;
        n_head   = r_head;
        n_status = r_status;
        n_clr    = r_clr;

        o_ram.we    = 1'b0;
        o_ram.waddr = r_dpos;
        o_ram.wdata = FS_FREE;
        o_ram.re    = issue;
        o_ram.raddr = r_rd_pos[IDX_W-1:0];

        if (issue) begin
            n_rd_pos = r_rd_pos + POS_W'(1);
            n_dv     = 1'b1;
        end

        unique case (r_state)
            S_CLEAR: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = r_clr[IDX_W-1:0];
                o_ram.wdata = FS_FREE;
                n_clr       = r_clr + POS_W'(1);
                n_free      = FREE_W'(i_cfg.size);
            end
            S_IDLE: begin
                if (i_req.valid) begin
                    n_kind = t_kind'(i_req.kind);
                    n_fno  = i_req.frame_num;
                    n_len  = i_req.run_length;
                end
            end
            S_DECODE: begin
                n_head   = '0;
                n_run    = '0;
                n_first  = 1'b1;
                n_status = ST_OK;
                unique case (r_kind)
                    K_ALLOC: begin
                        if (r_len == '0) n_status = ST_RANGE;
                        else if (alloc_bad) n_status = ST_NO_SPACE;
                        n_rd_pos = '0;
                        n_lim    = POS_W'(i_cfg.size);
                    end
                    K_RELEASE: begin
                        if (!in_pool) n_status = ST_RANGE;
                        n_rd_pos = POS_W'(off);
                        n_lim    = POS_W'(i_cfg.size);
                    end
                    K_MARK: begin
                        if (!((r_len != '0) && in_pool && mark_fits)) n_status = ST_RANGE;
                        n_rd_pos = POS_W'(off);
                        n_lim    = POS_W'(off) + POS_W'(r_len);
                    end
                    K_NONE: begin
                        n_status = ST_RANGE;
                    end
                    default: n_status = ST_RANGE;
                endcase
            end
            S_SCAN: begin
                if (r_dv) begin
                    n_run = rd_free ? (r_run + LEN_W'(1)) : '0;
                end
                if (found) begin
                    // restart the stream over the run just found
                    n_rd_pos = POS_W'(fit_start);
                    n_lim    = POS_W'(r_dpos) + POS_W'(1);
                    n_dv     = 1'b0;
                    n_first  = 1'b1;
                    n_head   = i_cfg.base + FRAME_W'(fit_start);
                end else if (stream_end) begin
                    n_status = ST_NO_SPACE;
                end
            end
            S_MARK: begin
                if (r_dv) begin
                    o_ram.we    = 1'b1;
                    o_ram.wdata = r_first ? FS_HEAD : FS_ALLOC;
                    n_first     = 1'b0;
                    if (rd_free && (r_free != '0)) n_free = r_free - FREE_W'(1);
                end
            end
            S_REL: begin
                if (r_dv && !rel_stop) begin
                    o_ram.we    = 1'b1;
                    o_ram.wdata = FS_FREE;
                    n_first     = 1'b0;
                    n_free      = r_free + FREE_W'(1);
                end
                if (r_dv && r_first && !rd_head) n_status = ST_NOT_HEAD;
            end
            S_DONE: begin
            end
            default: begin
            end
        endcase

        if (i_cfg.reinit) begin
            n_clr = '0;
            n_dv  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_dv    <= 1'b0;
            r_free  <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_dv    <= n_dv;
            r_free  <= n_free;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind   <= n_kind;
        r_fno    <= n_fno;
        r_len    <= n_len;
        r_rd_pos <= n_rd_pos;
        r_lim    <= n_lim;
        r_dpos   <= n_dpos;
        r_run    <= n_run;
        r_first  <= n_first;
        r_head   <= n_head;
        r_status <= n_status;
    end

    assign i_req.ready = (r_state == S_IDLE);

    assign o_res_valid       = (r_state == S_DONE);
    assign o_res.head        = r_head;
    assign o_res.status      = r_status;
    assign o_res.free_frames = r_free;

    a_free_in_pool: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_free <= FREE_W'(i_cfg.size)))
        else $error("free count exceeds pool size");

    a_accept_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready && !i_cfg.reinit) |=> (r_state == S_DECODE))
        else $error("accepted word not decoded");

    a_scan_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_run < r_len))
        else $error("scan run overran requested length");

    a_mark_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MARK && o_ram.we) |-> (POS_W'(o_ram.waddr) < r_lim))
        else $error("mark wrote past end of range");

endmodule

`default_nettype wire
